// ===== rtl/bsm_irq_pkg.sv =====
// Shared codes and constants for the bank switch mapper with IRQ counter.
// No dependencies; used by bank_switch_mapper_irq_counter.
package bsm_irq_pkg;

    localparam int CHR_SLOTS_DEF = 8;

    typedef logic [1:0] req_t;
    localparam req_t REQ_CPU_READ  = 2'd0;
    localparam req_t REQ_CPU_WRITE = 2'd1;
    localparam req_t REQ_PPU       = 2'd2;
    localparam req_t REQ_TICK      = 2'd3;

    typedef logic [1:0] tgt_t;
    localparam tgt_t TGT_NONE = 2'd0;
    localparam tgt_t TGT_PRG  = 2'd1;
    localparam tgt_t TGT_CHR  = 2'd2;
    localparam tgt_t TGT_NT   = 2'd3;

    // register select, CPU address bits 3..0
    typedef logic [3:0] reg_sel_t;
    localparam reg_sel_t REG_CHR_FIRST = 4'h0;
    localparam reg_sel_t REG_CHR_LAST  = 4'h7;
    localparam reg_sel_t REG_PRG       = 4'h8;
    localparam reg_sel_t REG_MIRROR    = 4'h9;
    localparam reg_sel_t REG_IRQ_CTRL  = 4'hA;
    localparam reg_sel_t REG_LATCH_LO  = 4'hB;
    localparam reg_sel_t REG_LATCH_HI  = 4'hC;

    typedef logic [1:0] mirror_t;
    localparam mirror_t MIR_VERT   = 2'd0;
    localparam mirror_t MIR_HORZ   = 2'd1;
    localparam mirror_t MIR_PAGE0  = 2'd2;
    localparam mirror_t MIR_PAGE1  = 2'd3;

    localparam logic [15:0] REG_BASE    = 16'h6000;
    localparam logic [3:0]  FIXED_BANK  = 4'hF;
    localparam logic [15:0] COUNT_WRAP  = 16'hFFFF;

endpackage

// ===== rtl/bank_switch_mapper_irq_counter.sv =====
// Bank switch mapper with IRQ down-counter: decode, address translation, counter.
// Depends on bsm_irq_pkg.
//
// Usage: each input item (req_type, bus_address, write_data) on the in_valid /
// in_ready channel is a CPU read, CPU write, PPU access or clock tick. Exactly
// one result item (target, mapped_address, irq_out) comes out on the
// out_valid / out_ready channel for each input item, in order.
// Each accepted item waits in the input register; when the result register is free
// or being taken, it moves on and out_valid rises. Decode, bank lookup and counter
// decrement go in one pass from the input register into the result register,
// where mapper state is updated at the same edge.
// Throughput is one item per cycle while out_ready stays high; the input register,
// the result register and the single-pass decode set that figure.
// When the receiver stalls, the result register holds, the input register
// fills behind it and in_ready drops until out_ready returns.
// Reset (rst_n low) clears all bank registers, mirroring, the counter, its latch
// and the IRQ level (irq_out itself is not reset), and empties both registers.
module bank_switch_mapper_irq_counter #(
    parameter int CHR_SLOTS = bsm_irq_pkg::CHR_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  target,
    output logic [17:0] mapped_address,
    output logic        irq_out
);

    localparam int SLOT_W = $clog2(CHR_SLOTS);

    // input register
    logic        in_valid_reg;
    logic [1:0]  type_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  target_reg, target_next;
    logic [17:0] maddr_reg, maddr_next;
    logic        irq_reg;

    // mapper state
    logic [7:0]  chr_bank_reg [CHR_SLOTS];
    logic [3:0]  prg_bank_reg, prg_bank_next;
    logic [1:0]  mirror_reg, mirror_next;
    logic        enable_reg, enable_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] latch_reg, latch_next;
    logic        irq_level_reg, irq_level_next;

    logic        advance;
    logic        chr_we;
    logic [15:0] count_dec;
    logic [13:0] ppu_addr;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign count_dec = count_reg - 16'd1;
    assign ppu_addr  = addr_reg[13:0];

    always_comb
    begin
        target_next    = bsm_irq_pkg::TGT_NONE;
        maddr_next     = '0;
        prg_bank_next  = prg_bank_reg;
        mirror_next    = mirror_reg;
        enable_next    = enable_reg;
        count_next     = count_reg;
        latch_next     = latch_reg;
        irq_level_next = irq_level_reg;
        chr_we         = 1'b0;

        case (type_reg)
            bsm_irq_pkg::REQ_CPU_READ:
            begin
                if (addr_reg[15])
                begin
                    target_next = bsm_irq_pkg::TGT_PRG;
                    maddr_next  = {(addr_reg[14] ? bsm_irq_pkg::FIXED_BANK : prg_bank_reg),
                                   addr_reg[13:0]};
                end
            end
            bsm_irq_pkg::REQ_CPU_WRITE:
            begin
                if (addr_reg >= bsm_irq_pkg::REG_BASE)
                begin
                    case (addr_reg[3:0]) inside
                        [bsm_irq_pkg::REG_CHR_FIRST:bsm_irq_pkg::REG_CHR_LAST]:
                            chr_we = 1'b1;
                        bsm_irq_pkg::REG_PRG:      prg_bank_next = data_reg[3:0];
                        bsm_irq_pkg::REG_MIRROR:   mirror_next   = data_reg[1:0];
                        bsm_irq_pkg::REG_IRQ_CTRL:
                        begin
                            irq_level_next = 1'b0;
                            enable_next    = data_reg[0];
                            count_next     = latch_reg;
                        end
                        bsm_irq_pkg::REG_LATCH_LO: latch_next = {latch_reg[15:8], data_reg};
                        bsm_irq_pkg::REG_LATCH_HI: latch_next = {data_reg, latch_reg[7:0]};
                        default: ;  // EEPROM port, not modeled
                    endcase
                end
            end
            bsm_irq_pkg::REQ_PPU:
            begin
                if (ppu_addr[13])
                begin
                    target_next = bsm_irq_pkg::TGT_NT;
                    case (mirror_reg)
                        bsm_irq_pkg::MIR_VERT:
                            maddr_next = {7'd0, ppu_addr[10], ppu_addr[9:0]};
                        bsm_irq_pkg::MIR_HORZ:
                            maddr_next = {7'd0, ppu_addr[11], ppu_addr[9:0]};
                        bsm_irq_pkg::MIR_PAGE0:
                            maddr_next = {7'd0, 1'b0, ppu_addr[9:0]};
                        default:
                            maddr_next = {7'd0, 1'b1, ppu_addr[9:0]};
                    endcase
                end
                else
                begin
                    target_next = bsm_irq_pkg::TGT_CHR;
                    maddr_next  = {chr_bank_reg[ppu_addr[10 +: SLOT_W]], ppu_addr[9:0]};
                end
            end
            default:
            begin
                // tick: wrap to all ones fires the IRQ and stops the counter
                if (enable_reg)
                begin
                    count_next = count_dec;
                    if (count_dec == bsm_irq_pkg::COUNT_WRAP)
                    begin
                        irq_level_next = 1'b1;
                        enable_next    = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_bank_reg  <= '0;
            mirror_reg    <= '0;
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            latch_reg     <= '0;
            irq_level_reg <= 1'b0;
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                chr_bank_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prg_bank_reg  <= prg_bank_next;
                mirror_reg    <= mirror_next;
                enable_reg    <= enable_next;
                count_reg     <= count_next;
                latch_reg     <= latch_next;
                irq_level_reg <= irq_level_next;
                if (chr_we)
                begin
                    chr_bank_reg[addr_reg[SLOT_W-1:0]] <= data_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            type_reg <= req_type;
            addr_reg <= bus_address;
            data_reg <= write_data;
        end
        if (advance)
        begin
            target_reg <= target_next;
            maddr_reg  <= maddr_next;
            irq_reg    <= irq_level_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target         = target_reg;
    assign mapped_address = maddr_reg;
    assign irq_out        = irq_reg;

endmodule

// ===== tb/bank_switch_mapper_irq_counter_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bank_switch_mapper_irq_counter: directed and random bus traffic,
// with an in-bench mapper predictor and in-order result checks. Depends on bsm_irq_pkg.
module bank_switch_mapper_irq_counter_test;

    localparam int CHR_COUNT    = bsm_irq_pkg::CHR_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1625;
    localparam int CYCLE_LIMIT  = 300000;
    localparam bsm_irq_pkg::reg_sel_t REG_EEPROM = 4'hD;    // not decoded by the block

    typedef struct packed {
        bsm_irq_pkg::tgt_t tgt;
        logic [17:0]       maddr;
        logic              irq;
    } mapper_result_t;

    // Tracks mapper state and holds the results still owed by the block.
    class mapper_tracker;
        mapper_result_t pending[$];
        bit [7:0]  chr_bank[CHR_COUNT];
        bit [3:0]  prg_bank;
        bit [1:0]  mirror;
        bit        cnt_en;
        bit [15:0] count;
        bit [15:0] latch;
        bit        irq;
        int        errors, checked, wraps;
        int        per_req[4];

        function void note_access(bsm_irq_pkg::req_t req, logic [15:0] addr,
                                  logic [7:0] data);
            mapper_result_t        res;
            bsm_irq_pkg::reg_sel_t sel;
            logic [3:0]            bank;
            logic                  page;
            res = '0;
            sel = addr[3:0];
            per_req[req]++;
            case (req)
                bsm_irq_pkg::REQ_CPU_READ:
                    if (addr[15])
                    begin
                        bank = addr[14] ? bsm_irq_pkg::FIXED_BANK : prg_bank;
                        res.tgt = bsm_irq_pkg::TGT_PRG;
                        res.maddr = {bank, addr[13:0]};
                    end
                bsm_irq_pkg::REQ_CPU_WRITE:
                    if (addr >= bsm_irq_pkg::REG_BASE)
                    begin
                        if (sel <= bsm_irq_pkg::REG_CHR_LAST)
                            chr_bank[sel[2:0]] = data;
                        else
                            case (sel)
                                bsm_irq_pkg::REG_PRG:      prg_bank = data[3:0];
                                bsm_irq_pkg::REG_MIRROR:   mirror = data[1:0];
                                bsm_irq_pkg::REG_IRQ_CTRL:
                                begin
                                    irq = 1'b0;
                                    cnt_en = data[0];
                                    count = latch;
                                end
                                bsm_irq_pkg::REG_LATCH_LO: latch[7:0] = data;
                                bsm_irq_pkg::REG_LATCH_HI: latch[15:8] = data;
                                default: ;
                            endcase
                    end
                bsm_irq_pkg::REQ_PPU:
                    if (addr[13])
                    begin
                        case (mirror)
                            bsm_irq_pkg::MIR_VERT:  page = addr[10];
                            bsm_irq_pkg::MIR_HORZ:  page = addr[11];
                            bsm_irq_pkg::MIR_PAGE0: page = 1'b0;
                            default:                page = 1'b1;
                        endcase
                        res.tgt = bsm_irq_pkg::TGT_NT;
                        res.maddr = {7'd0, page, addr[9:0]};
                    end
                    else
                    begin
                        res.tgt = bsm_irq_pkg::TGT_CHR;
                        res.maddr = {chr_bank[addr[12:10]], addr[9:0]};
                    end
                default:
                    if (cnt_en)
                    begin
                        count = count - 16'd1;
                        if (count == bsm_irq_pkg::COUNT_WRAP)
                        begin
                            irq = 1'b1;
                            cnt_en = 1'b0;
                            wraps++;
                        end
                    end
            endcase
            res.irq = irq;
            pending.push_back(res);
        endfunction

        function void check_result(bsm_irq_pkg::tgt_t tgt, logic [17:0] maddr,
                                   logic irq_seen);
            mapper_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: expected none, actual target %0d addr %05h irq %0b",
                         $time, tgt, maddr, irq_seen);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (tgt !== want.tgt)
            begin
                errors++;
                $display("%0t: target: expected %0d, actual %0d", $time, want.tgt, tgt);
            end
            if (maddr !== want.maddr)
            begin
                errors++;
                $display("%0t: mapped_address: expected %05h, actual %05h",
                         $time, want.maddr, maddr);
            end
            if (irq_seen !== want.irq)
            begin
                errors++;
                $display("%0t: irq_out: expected %0b, actual %0b", $time, want.irq, irq_seen);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  target;
    logic [17:0] mapped_address;
    logic        irq_out;

    mapper_tracker tracker = new();
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_cycles;
    int cycle_count;

    bank_switch_mapper_irq_counter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .bus_address    (bus_address),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .target         (target),
        .mapped_address (mapped_address),
        .irq_out        (irq_out)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items still owed", $time, tracker.pending.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // handshakes seen at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_access(req_type, bus_address, write_data);
            if (out_valid && out_ready)
                tracker.check_result(target, mapped_address, irq_out);
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (!rx_idle_on)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 11);
                else
                    run_left = $urandom_range(1, 30);
            end
        end
    end

    // returns at the edge where the item is taken; valid stays up until the next change
    task automatic offer_access(bsm_irq_pkg::req_t req, logic [15:0] addr, logic [7:0] data);
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= req;
        bus_address <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(bsm_irq_pkg::reg_sel_t sel, logic [7:0] data);
        offer_access(bsm_irq_pkg::REQ_CPU_WRITE, bsm_irq_pkg::REG_BASE | 16'(sel), data);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_access();
        int                    pick;
        logic [15:0]           addr;
        logic [7:0]            data;
        bsm_irq_pkg::reg_sel_t sel;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 16'hFFFF));
        data = 8'($urandom_range(0, 255));
        if (pick < 25)
            offer_access(bsm_irq_pkg::REQ_CPU_READ, addr, data);
        else if (pick < 45)
            offer_access(bsm_irq_pkg::REQ_PPU, addr, data);
        else if (pick < 62)
            offer_access(bsm_irq_pkg::REQ_TICK, addr, data);
        else if (pick < 92)
        begin
            sel = bsm_irq_pkg::reg_sel_t'($urandom_range(0, 15));
            addr = 16'($urandom_range(bsm_irq_pkg::REG_BASE, 16'hFFFF));
            addr[3:0] = sel;
            // keep reload values short so the counter wraps often
            if (sel == bsm_irq_pkg::REG_LATCH_HI && $urandom_range(0, 3) != 0)
                data = 8'd0;
            else if (sel == bsm_irq_pkg::REG_LATCH_LO && $urandom_range(0, 1) == 0)
                data = 8'($urandom_range(0, 15));
            offer_access(bsm_irq_pkg::REQ_CPU_WRITE, addr, data);
        end
        else
            offer_access(bsm_irq_pkg::REQ_CPU_WRITE,
                         16'($urandom_range(0, bsm_irq_pkg::REG_BASE - 1)), data);
    endtask

    initial
    begin : stimulus
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = bsm_irq_pkg::REQ_CPU_READ;
        bus_address = '0;
        write_data = '0;
        out_ready = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: open bus, PRG windows, ignored writes, CHR slots, mirroring, counter
        offer_access(bsm_irq_pkg::REQ_CPU_READ, 16'h7FFF, 8'h00);
        offer_access(bsm_irq_pkg::REQ_CPU_WRITE, 16'h5FF8, 8'hFF);
        offer_access(bsm_irq_pkg::REQ_CPU_READ, 16'hBFFF, 8'h00);
        write_reg(bsm_irq_pkg::REG_PRG, 8'hFF);
        offer_access(bsm_irq_pkg::REQ_CPU_READ, 16'h8000, 8'h00);
        offer_access(bsm_irq_pkg::REQ_CPU_READ, 16'hC000, 8'h00);
        write_reg(bsm_irq_pkg::REG_CHR_FIRST, 8'hFF);
        offer_access(bsm_irq_pkg::REQ_CPU_WRITE, 16'hFFF7, 8'h80);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'hC3FF, 8'h00);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'h1FFF, 8'h00);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'h3BFF, 8'h00);
        write_reg(bsm_irq_pkg::REG_MIRROR, 8'hFD);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'h2BFF, 8'h00);
        write_reg(bsm_irq_pkg::REG_MIRROR, 8'h02);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'hFFFF, 8'h00);
        write_reg(bsm_irq_pkg::REG_MIRROR, 8'h03);
        offer_access(bsm_irq_pkg::REQ_PPU, 16'h2000, 8'h00);
        write_reg(bsm_irq_pkg::REG_LATCH_LO, 8'h01);
        write_reg(bsm_irq_pkg::REG_LATCH_HI, 8'h00);
        write_reg(bsm_irq_pkg::REG_IRQ_CTRL, 8'hFF);
        repeat (3) offer_access(bsm_irq_pkg::REQ_TICK, 16'hFFFF, 8'hFF);
        write_reg(REG_EEPROM, 8'hFF);
        write_reg(bsm_irq_pkg::REG_IRQ_CTRL, 8'h00);
        offer_access(bsm_irq_pkg::REQ_TICK, 16'h0000, 8'h00);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 500)
                rx_hold_cycles = 250;
            if (i == 1000)
                drain_results();
            if (i == RANDOM_ITEMS - 300)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_access();
            if (tx_idle_on && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 11));
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d reads, %0d writes, %0d PPU accesses, %0d ticks; checked %0d items",
                 tracker.per_req[bsm_irq_pkg::REQ_CPU_READ],
                 tracker.per_req[bsm_irq_pkg::REQ_CPU_WRITE],
                 tracker.per_req[bsm_irq_pkg::REQ_PPU],
                 tracker.per_req[bsm_irq_pkg::REQ_TICK], tracker.checked);
        $display("Counter wrapped to IRQ %0d times", tracker.wraps);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
